/* rtl/pdcap_pkg.sv */
// ----------------------------------------------------------------------------
// pdcap_pkg
// shared types and constants of the three channel pwm duty capture block
// ----------------------------------------------------------------------------
package pdcap_pkg;

   // duty and period widths
   localparam int DUTY_BITS   = 13;
   localparam int PERIOD_BITS = 20;
   localparam int FRAC_BITS   = 12;

   localparam logic [DUTY_BITS-1:0]   FULL_DUTY    = 13'd4096;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd10000;

   // last divider step index (one quotient bit per step)
   localparam logic [3:0] LAST_STEP = 4'(FRAC_BITS - 1);

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } ctrl_state_type;

   // status a lane hands to the merge logic
   typedef struct packed {
      logic                 done;
      logic [DUTY_BITS-1:0] duty;
   } lane_status_type;

endpackage

/* rtl/pwm_duty_capture_three_channel_top.sv */
// ----------------------------------------------------------------------------
// pwm_duty_capture_three_channel_top
// duty capture of three sampled pwm inputs with a lane per channel
// ----------------------------------------------------------------------------
//  channel   direction  ports                        transfer
//  req       in         now_us, three pin levels     valid / ready
//  rsp       out        fan, water, fuel duty        valid / ready
//  csr       in         pwm period (20 bits)         write enable, no wait
//
//  after accept the block waits in calc until all lanes are done and the rsp
//  slot is free; a falling edge within a period of the last rise first runs
//  that lane's 12-step serial divider. req_ready returns with rsp_valid, so
//  a new request waits until the last one is published; the response register
//  holds the result under rsp stalls.
//  synchronous reset clears all channel state and sets the period to 10000.
// ----------------------------------------------------------------------------
module pwm_duty_capture_three_channel_top #(
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [TIME_BITS-1:0]                req_now_us,
   input  logic                                req_fan_level,
   input  logic                                req_water_level,
   input  logic                                req_fuel_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pdcap_pkg::DUTY_BITS-1:0]     rsp_fan_duty,
   output logic [pdcap_pkg::DUTY_BITS-1:0]     rsp_water_duty,
   output logic [pdcap_pkg::DUTY_BITS-1:0]     rsp_fuel_duty,
   input  logic                                csr_wr_en,
   input  logic [pdcap_pkg::PERIOD_BITS-1:0]   csr_wr_data
);

   pdcap_pkg::ctrl_state_type           state_ff, state_in;
   logic [pdcap_pkg::PERIOD_BITS-1:0]   period_ff;
   logic [pdcap_pkg::PERIOD_BITS-1:0]   period_eff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [pdcap_pkg::DUTY_BITS-1:0]     fan_duty_ff;
   logic [pdcap_pkg::DUTY_BITS-1:0]     water_duty_ff;
   logic [pdcap_pkg::DUTY_BITS-1:0]     fuel_duty_ff;
   logic                                accept;
   logic                                lanes_done;
   logic                                publish;

   pdcap_pkg::lane_status_type          fan_status;
   pdcap_pkg::lane_status_type          water_status;
   pdcap_pkg::lane_status_type          fuel_status;

   // period register, zero acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= pdcap_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   assign period_eff = (period_ff == '0) ? pdcap_pkg::PERIOD_BITS'(1) : period_ff;

   assign req_ready = (state_ff == pdcap_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;

   // one lane per channel
   pdcap_lane #(.TIME_BITS(TIME_BITS)) u_fan_lane (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .now    (req_now_us),
      .level  (req_fan_level),
      .period (period_eff),
      .status (fan_status)
   );

   pdcap_lane #(.TIME_BITS(TIME_BITS)) u_water_lane (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .now    (req_now_us),
      .level  (req_water_level),
      .period (period_eff),
      .status (water_status)
   );

   pdcap_lane #(.TIME_BITS(TIME_BITS)) u_fuel_lane (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .now    (req_now_us),
      .level  (req_fuel_level),
      .period (period_eff),
      .status (fuel_status)
   );

   // merge: wait for all lanes and a free response slot
   assign lanes_done = fan_status.done & water_status.done & fuel_status.done;
   assign publish    = (state_ff == pdcap_pkg::ST_CALC) & lanes_done &
                       (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         pdcap_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pdcap_pkg::ST_CALC;
            end
         end
         pdcap_pkg::ST_CALC: begin
            if (publish) begin
               state_in     = pdcap_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = pdcap_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdcap_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (publish) begin
         fan_duty_ff   <= fan_status.duty;
         water_duty_ff <= water_status.duty;
         fuel_duty_ff  <= fuel_status.duty;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fan_duty   = fan_duty_ff;
   assign rsp_water_duty = water_duty_ff;
   assign rsp_fuel_duty  = fuel_duty_ff;

   // checks
   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == pdcap_pkg::ST_CALC))
      else $error("accepted transaction did not enter calc");

   a_publish: assert property (@(posedge clock) disable iff (reset)
      publish |=> (rsp_valid_ff && state_ff == pdcap_pkg::ST_IDLE))
      else $error("finished result was not published");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fan_duty <= pdcap_pkg::FULL_DUTY &&
                        rsp_water_duty <= pdcap_pkg::FULL_DUTY &&
                        rsp_fuel_duty <= pdcap_pkg::FULL_DUTY))
      else $error("duty above full scale");

endmodule

/* rtl/pdcap_lane.sv */
// ----------------------------------------------------------------------------
// pdcap_lane
// one capture channel: edge and timeout tracking plus a radix-2 serial divider
// ----------------------------------------------------------------------------
module pdcap_lane #(
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [TIME_BITS-1:0]                now,
   input  logic                                level,
   input  logic [pdcap_pkg::PERIOD_BITS-1:0]   period,
   output pdcap_pkg::lane_status_type          status
);

   localparam int CMP_BITS = (TIME_BITS > pdcap_pkg::PERIOD_BITS) ?
                             TIME_BITS : pdcap_pkg::PERIOD_BITS;

   // channel state
   logic                              prev_ff,   prev_in;
   logic [TIME_BITS-1:0]              rise_ff,   rise_in;
   logic [TIME_BITS-1:0]              fall_ff,   fall_in;
   logic [pdcap_pkg::DUTY_BITS-1:0]   duty_ff,   duty_in;

   // divider state
   logic                              busy_ff,   busy_in;
   logic [3:0]                        step_ff,   step_in;
   logic [pdcap_pkg::PERIOD_BITS-1:0] rem_ff,    rem_in;
   logic [pdcap_pkg::FRAC_BITS-1:0]   quo_ff,    quo_in;

   logic [TIME_BITS-1:0]              diff_rise;
   logic [TIME_BITS-1:0]              diff_fall;
   logic                              rise_late;
   logic                              fall_late;
   logic                              rising;
   logic                              falling;

   logic [pdcap_pkg::PERIOD_BITS:0]   shifted;
   logic                              take;
   logic [pdcap_pkg::PERIOD_BITS-1:0] rem_next;
   logic [pdcap_pkg::FRAC_BITS-1:0]   quo_next;
   logic [pdcap_pkg::DUTY_BITS-1:0]   quo_ceil;

   // wrapped ages of both stamps against the period
   assign diff_rise = now - rise_ff;
   assign diff_fall = now - fall_ff;
   assign rise_late = CMP_BITS'(diff_rise) >= CMP_BITS'(period);
   assign fall_late = CMP_BITS'(diff_fall) >= CMP_BITS'(period);
   assign rising    = level & ~prev_ff;
   assign falling   = ~level & prev_ff;

   // one restoring step: remainder stays below the period
   assign shifted  = {rem_ff, 1'b0};
   assign take     = shifted >= {1'b0, period};
   assign rem_next = take ? pdcap_pkg::PERIOD_BITS'(shifted - {1'b0, period})
                          : shifted[pdcap_pkg::PERIOD_BITS-1:0];
   assign quo_next = {quo_ff[pdcap_pkg::FRAC_BITS-2:0], take};

   // rounded-up quotient, at most full scale
   assign quo_ceil = {1'b0, quo_next} +
                     pdcap_pkg::DUTY_BITS'(rem_next != '0);

   // next-state logic
   always_comb begin
      prev_in = prev_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      duty_in = duty_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         prev_in = level;
         // stamp renewal on edges or timeouts
         if (rising || (!rising && rise_late)) begin
            rise_in = now;
         end
         if (falling || (!falling && fall_late)) begin
            fall_in = now;
         end
         if (falling) begin
            if (rise_late) begin
               duty_in = '0;
            end else begin
               busy_in = 1'b1;
               step_in = '0;
               rem_in  = pdcap_pkg::PERIOD_BITS'(diff_rise);
               quo_in  = '0;
            end
         end else if (!rising && rise_late && level) begin
            duty_in = '0;
         end else if (fall_late && !level) begin
            duty_in = pdcap_pkg::FULL_DUTY;
         end
      end else if (busy_ff) begin
         rem_in  = rem_next;
         quo_in  = quo_next;
         step_in = step_ff + 4'd1;
         if (step_ff == pdcap_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            duty_in = pdcap_pkg::FULL_DUTY - quo_ceil;
         end
      end
   end

   // control and channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
         rise_ff <= '0;
         fall_ff <= '0;
         duty_ff <= '0;
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         duty_ff <= duty_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.done = ~busy_ff;
   assign status.duty = duty_ff;

endmodule
